// File: hdl/ctq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctq_pkg: shared types and constants of the chunked ticket queue
// Queue depth, field widths, command and status codes, and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ctq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int FUNC_W   = 2;
  localparam int TICKET_W = 16;
  localparam int PEOPLE_W = 8;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  localparam logic [PEOPLE_W-1:0] CHUNK_RESET = 8'd4;

  localparam logic [FUNC_W-1:0] FN_ENQUEUE = 2'd0;
  localparam logic [FUNC_W-1:0] FN_SERVE   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CANCEL  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_APPEND = 2'd1,
    WR_CHUNK  = 2'd2,
    WR_SHIFT  = 2'd3
  } wr_op_t;

  typedef struct packed {
    logic                capture;
    logic                rd_zero;
    logic                rd_next;
    wr_op_t              wr_op;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
    logic                take_head;
    logic                out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              empty;
    logic              head_big;
    logic              match;
    logic              more;
    logic              out_busy;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: hdl/ctq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctq_ctrl: command sequencer of the chunked ticket queue
// Decodes the captured command, steps the head read, the ticket scan and the
// compaction shift, and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module ctq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ctq_pkg::dp_sts_t sts,
  output ctq_pkg::dp_cmd_t      cmd
);
  import ctq_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_HEAD     = 6'b000100,
    S_SCAN     = 6'b001000,
    S_SHIFT    = 6'b010000,
    S_FINISH   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.wr_op       = WR_NONE;
    cmd.status_code = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.func)
          FN_ENQUEUE: begin
            if (sts.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
            end else begin
              cmd.wr_op   = WR_APPEND;
              cmd.cnt_inc = 1'b1;
            end
            state_nxt = S_FINISH;
          end
          FN_SERVE: begin
            if (sts.empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_EMPTY;
              state_nxt       = S_FINISH;
            end else begin
              cmd.rd_zero = 1'b1;
              state_nxt   = S_HEAD;
            end
          end
          FN_CANCEL: begin
            if (sts.empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_NOT_FOUND;
              state_nxt       = S_FINISH;
            end else begin
              cmd.rd_zero = 1'b1;
              state_nxt   = S_SCAN;
            end
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_HEAD: begin
        cmd.take_head = 1'b1;
        if (sts.head_big) begin
          cmd.wr_op = WR_CHUNK;
          state_nxt = S_FINISH;
        end else if (sts.more) begin
          cmd.rd_next = 1'b1;
          state_nxt   = S_SHIFT;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FINISH;
        end
      end
      S_SCAN: begin
        if (sts.match) begin
          if (sts.more) begin
            cmd.rd_next = 1'b1;
            state_nxt   = S_SHIFT;
          end else begin
            cmd.cnt_dec = 1'b1;
            state_nxt   = S_FINISH;
          end
        end else if (sts.more) begin
          cmd.rd_next = 1'b1;
        end else begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_NOT_FOUND;
          state_nxt       = S_FINISH;
        end
      end
      S_SHIFT: begin
        cmd.wr_op = WR_SHIFT;
        if (sts.more) begin
          cmd.rd_next = 1'b1;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/ctq_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctq_dpath: entry store and result path of the chunked ticket queue
// Holds the entries with the head at slot zero, the entry count, the chunk
// limit, the scan index, the command word and the registered result word.
// ----------------------------------------------------------------------------
module ctq_dpath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ctq_pkg::dp_cmd_t               cmd,
  output ctq_pkg::dp_sts_t                    sts,
  input  wire logic                           cfg_wr_en,
  input  wire logic [ctq_pkg::PEOPLE_W-1:0]   cfg_wr_data,
  input  wire logic [ctq_pkg::FUNC_W-1:0]     in_func,
  input  wire logic [ctq_pkg::TICKET_W-1:0]   in_ticket,
  input  wire logic [ctq_pkg::PEOPLE_W-1:0]   in_people,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ctq_pkg::STATUS_W-1:0]        out_status,
  output logic [ctq_pkg::TICKET_W-1:0]        out_served_ticket,
  output logic [ctq_pkg::PEOPLE_W-1:0]        out_served_people,
  output logic                                out_is_empty,
  output logic [ctq_pkg::OCC_W-1:0]           out_occupancy
);
  import ctq_pkg::*;

  logic [TICKET_W-1:0] tick_mem [QUEUE_DEPTH];
  logic [PEOPLE_W-1:0] ppl_mem  [QUEUE_DEPTH];

  logic [FUNC_W-1:0]   func_r;
  logic [TICKET_W-1:0] key_r;
  logic [PEOPLE_W-1:0] ppl_r;
  logic [PEOPLE_W-1:0] limit_r, limit_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic [TICKET_W-1:0] rd_ticket_r;
  logic [PEOPLE_W-1:0] rd_people_r;
  logic [STATUS_W-1:0] status_r;
  logic [TICKET_W-1:0] srv_ticket_r;
  logic [PEOPLE_W-1:0] srv_people_r;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [TICKET_W-1:0] out_ticket_r;
  logic [PEOPLE_W-1:0] out_people_r;
  logic                out_empty_r;
  logic [OCC_W-1:0]    out_occ_r;

  logic [PEOPLE_W-1:0] lim_eff;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [TICKET_W-1:0] wr_ticket;
  logic [PEOPLE_W-1:0] wr_people;

  assign lim_eff = (limit_r == '0) ? PEOPLE_W'(1) : limit_r;

  assign sts.func     = func_r;
  assign sts.full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign sts.empty    = (count_r == '0);
  assign sts.head_big = (rd_people_r > lim_eff);
  assign sts.match    = (rd_ticket_r == key_r);
  assign sts.more     = ((CNT_W+1)'(idx_r) + (CNT_W+1)'(1)) < (CNT_W+1)'(count_r);
  assign sts.out_busy = out_valid_r && !out_ready;

  always_comb begin
    if (cmd.rd_zero) begin
      rd_addr = '0;
    end else if (cmd.rd_next) begin
      rd_addr = idx_r + ADDR_W'(1);
    end else begin
      rd_addr = idx_r;
    end
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_ticket = rd_ticket_r;
    wr_people = rd_people_r;
    case (cmd.wr_op)
      WR_APPEND: begin
        wr_en     = 1'b1;
        wr_addr   = count_r[ADDR_W-1:0];
        wr_ticket = key_r;
        wr_people = ppl_r;
      end
      WR_CHUNK: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_people = rd_people_r - lim_eff;
      end
      WR_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_r - ADDR_W'(1);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // entry store: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tick_mem[wr_addr] <= wr_ticket;
      ppl_mem[wr_addr]  <= wr_people;
    end
    rd_ticket_r <= tick_mem[rd_addr];
    rd_people_r <= ppl_mem[rd_addr];
  end

  always_comb begin
    limit_nxt = cfg_wr_en ? cfg_wr_data : limit_r;
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
    idx_nxt = idx_r;
    if (cmd.rd_zero) begin
      idx_nxt = '0;
    end else if (cmd.rd_next) begin
      idx_nxt = idx_r + ADDR_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= CHUNK_RESET;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      limit_r     <= limit_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r       <= in_func;
      key_r        <= in_ticket;
      ppl_r        <= in_people;
      status_r     <= ST_OK;
      srv_ticket_r <= '0;
      srv_people_r <= '0;
    end else begin
      if (cmd.set_status) begin
        status_r <= cmd.status_code;
      end
      if (cmd.take_head) begin
        srv_ticket_r <= rd_ticket_r;
        srv_people_r <= sts.head_big ? lim_eff : rd_people_r;
      end
    end
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_ticket_r <= srv_ticket_r;
      out_people_r <= srv_people_r;
      out_empty_r  <= (count_r == '0);
      out_occ_r    <= OCC_W'(count_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_served_ticket = out_ticket_r;
  assign out_served_people = out_people_r;
  assign out_is_empty      = out_empty_r;
  assign out_occupancy     = out_occ_r;

endmodule
`default_nettype wire

// File: hdl/chunked_ticket_queue_top.sv
`default_nettype none
// Sequence: enqueue, the no-op and empty or full reports go from dispatch straight
//   to finish, a chunked serve goes through the head read, and a pop or a cancel
//   goes through the one-entry-a-cycle scan and shift.
// Throughput: one word at a time; the next word is taken the cycle after the
//   result enters the output register, which may still wait on out_ready.
// Reset: synchronous, active low; empties the queue, chunk limit back to 4.
// ----------------------------------------------------------------------------
// chunked_ticket_queue_top: bounded ticket queue with chunked serve and cancel
// Controller sequences enqueue, serve and cancel-by-ticket over the datapath.
// ----------------------------------------------------------------------------
module chunked_ticket_queue_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [ctq_pkg::PEOPLE_W-1:0]   cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ctq_pkg::FUNC_W-1:0]     in_func,
  input  wire logic [ctq_pkg::TICKET_W-1:0]   in_ticket,
  input  wire logic [ctq_pkg::PEOPLE_W-1:0]   in_people,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ctq_pkg::STATUS_W-1:0]        out_status,
  output logic [ctq_pkg::TICKET_W-1:0]        out_served_ticket,
  output logic [ctq_pkg::PEOPLE_W-1:0]        out_served_people,
  output logic                                out_is_empty,
  output logic [ctq_pkg::OCC_W-1:0]           out_occupancy
);
  import ctq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ctq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ctq_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_func           (in_func),
    .in_ticket         (in_ticket),
    .in_people         (in_people),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_served_ticket (out_served_ticket),
    .out_served_people (out_served_people),
    .out_is_empty      (out_is_empty),
    .out_occupancy     (out_occupancy)
  );

endmodule
`default_nettype wire

// File: tb/tb_chunked_ticket_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chunked_ticket_queue_top: self-checking bench for the chunked ticket queue
// Drives enqueue, serve, cancel and no-op words with random gaps on both
// channels. Each accepted word is predicted by a bit-accurate queue model in a
// scoreboard, and every result word is checked field by field, in order. The
// chunk limit is moved between phases, across its extremes.
// ----------------------------------------------------------------------------
module tb_chunked_ticket_queue_top;
  import ctq_pkg::*;

  localparam logic [FUNC_W-1:0] FN_NONE = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = QUEUE_DEPTH + 8;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TICKET_W-1:0] served_ticket;
    logic [PEOPLE_W-1:0] served_people;
    logic                is_empty;
    logic [OCC_W-1:0]    occupancy;
  } queue_result_t;

  class ticket_queue_scoreboard;
    logic [TICKET_W-1:0] slot_ticket [QUEUE_DEPTH];
    logic [PEOPLE_W-1:0] slot_people [QUEUE_DEPTH];
    int unsigned         held;
    logic [PEOPLE_W-1:0] chunk;
    queue_result_t       pending_results [$];
    int unsigned         errors;

    function new();
      held   = 0;
      chunk  = CHUNK_RESET;
      errors = 0;
    endfunction

    function void close_gap(int unsigned pos);
      for (int unsigned i = pos; i + 1 < held; i++) begin
        slot_ticket[i] = slot_ticket[i + 1];
        slot_people[i] = slot_people[i + 1];
      end
      held--;
    endfunction

    function logic [TICKET_W-1:0] held_ticket();
      return slot_ticket[$urandom_range(held - 1)];
    endfunction

    function queue_result_t queue_result(logic [FUNC_W-1:0] func,
                                         logic [TICKET_W-1:0] ticket,
                                         logic [PEOPLE_W-1:0] people);
      queue_result_t       r;
      logic [PEOPLE_W-1:0] lim;
      bit                  found;
      r     = '0;
      lim   = (chunk == '0) ? PEOPLE_W'(1) : chunk;
      found = 1'b0;
      case (func)
        FN_ENQUEUE: begin
          if (held >= QUEUE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            slot_ticket[held] = ticket;
            slot_people[held] = people;
            held++;
          end
        end
        FN_SERVE: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else if (slot_people[0] > lim) begin
            r.served_ticket = slot_ticket[0];
            r.served_people = lim;
            slot_people[0]  = slot_people[0] - lim;
          end else begin
            r.served_ticket = slot_ticket[0];
            r.served_people = slot_people[0];
            close_gap(0);
          end
        end
        FN_CANCEL: begin
          r.status = ST_NOT_FOUND;
          for (int unsigned i = 0; i < held && !found; i++) begin
            if (slot_ticket[i] == ticket) begin
              close_gap(i);
              r.status = ST_OK;
              found    = 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.is_empty  = (held == 0);
      r.occupancy = OCC_W'(held);
      return r;
    endfunction

    function void note_word(logic [FUNC_W-1:0] func, logic [TICKET_W-1:0] ticket,
                            logic [PEOPLE_W-1:0] people);
      pending_results.push_back(queue_result(func, ticket, people));
    endfunction

    task report(string what);
      $display("ERROR at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_word(queue_result_t got);
      queue_result_t want;
      if (pending_results.size() == 0) begin
        report("result word with none expected");
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.served_ticket !== want.served_ticket)
        report($sformatf("served_ticket %h, expected %h",
                         got.served_ticket, want.served_ticket));
      if (got.served_people !== want.served_people)
        report($sformatf("served_people %0d, expected %0d",
                         got.served_people, want.served_people));
      if (got.is_empty !== want.is_empty)
        report($sformatf("is_empty %b, expected %b", got.is_empty, want.is_empty));
      if (got.occupancy !== want.occupancy)
        report($sformatf("occupancy %0d, expected %0d", got.occupancy, want.occupancy));
    endtask
  endclass

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_wr_en   = 1'b0;
  logic [PEOPLE_W-1:0] cfg_wr_data = '0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic [FUNC_W-1:0]   in_func     = '0;
  logic [TICKET_W-1:0] in_ticket   = '0;
  logic [PEOPLE_W-1:0] in_people   = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [TICKET_W-1:0] out_served_ticket;
  logic [PEOPLE_W-1:0] out_served_people;
  logic                out_is_empty;
  logic [OCC_W-1:0]    out_occupancy;

  ticket_queue_scoreboard sb = new();
  int send_idle = 23;
  int recv_idle = 78;
  int hold_left = 0;
  int stall_cycles = 0;

  chunked_ticket_queue_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_ticket         (in_ticket),
    .in_people         (in_people),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_served_ticket (out_served_ticket),
    .out_served_people (out_served_people),
    .out_is_empty      (out_is_empty),
    .out_occupancy     (out_occupancy)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      sb.check_word({out_status, out_served_ticket, out_served_people,
                     out_is_empty, out_occupancy});
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic push_word(logic [FUNC_W-1:0] f, logic [TICKET_W-1:0] t,
                           logic [PEOPLE_W-1:0] p);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= f;
    in_ticket <= t;
    in_people <= p;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_word(f, t, p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_chunk(logic [PEOPLE_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.chunk = v;
  endtask

  task automatic run_random(int n);
    int                  enq_burst;
    int                  srv_burst;
    int                  r;
    logic [FUNC_W-1:0]   f;
    logic [TICKET_W-1:0] t;
    logic [PEOPLE_W-1:0] p;
    enq_burst = 0;
    srv_burst = 0;
    for (int i = 0; i < n; i++) begin
      if (enq_burst > 0) begin
        f = FN_ENQUEUE;
        enq_burst--;
      end else if (srv_burst > 0) begin
        f = FN_SERVE;
        srv_burst--;
      end else begin
        r = $urandom_range(99);
        if (r < 4) enq_burst = 18;
        else if (r < 8) srv_burst = 30;
        r = $urandom_range(99);
        if (r < 40) f = FN_ENQUEUE;
        else if (r < 68) f = FN_SERVE;
        else if (r < 92) f = FN_CANCEL;
        else f = FN_NONE;
      end
      if (f == FN_CANCEL && sb.held > 0 && $urandom_range(3) != 0)
        t = sb.held_ticket();
      else if ($urandom_range(1) == 0)
        t = TICKET_W'($urandom_range(31));
      else
        t = TICKET_W'($urandom);
      case ($urandom_range(3))
        0: p = PEOPLE_W'($urandom_range(8));
        1: p = PEOPLE_W'($urandom);
        2: p = sb.chunk - PEOPLE_W'(1) + PEOPLE_W'($urandom_range(2));
        default: p = PEOPLE_W'($urandom_range(255, 240));
      endcase
      push_word(f, t, p);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    push_word(FN_SERVE, 16'h0000, 8'd0);
    push_word(FN_CANCEL, 16'h0000, 8'd0);
    push_word(FN_ENQUEUE, 16'h0000, 8'd0);
    push_word(FN_ENQUEUE, 16'hFFFF, 8'hFF);
    push_word(FN_SERVE, 16'hFFFF, 8'hFF);
    push_word(FN_SERVE, 16'h0000, 8'd0);
    push_word(FN_CANCEL, 16'hFFFF, 8'd0);
    push_word(FN_NONE, TICKET_W'($urandom), PEOPLE_W'($urandom));
    push_word(FN_ENQUEUE, 16'h1234, 8'd4);
    push_word(FN_SERVE, 16'h0000, 8'd0);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      push_word(FN_ENQUEUE, TICKET_W'(i % 8), PEOPLE_W'($urandom));
    push_word(FN_ENQUEUE, 16'hAAAA, 8'h55);
    push_word(FN_CANCEL, 16'h0003, 8'd0);
    push_word(FN_NONE, TICKET_W'($urandom), PEOPLE_W'($urandom));

    drain();
    set_chunk(8'd1);
    run_random(330);

    drain();
    send_idle = 78;
    recv_idle = 23;
    set_chunk(8'd255);
    run_random(330);

    drain();
    send_idle = 0;
    recv_idle = 0;
    set_chunk(8'd0);
    run_random(150);
    hold_left = 400;
    run_random(40);

    drain();
    set_chunk(PEOPLE_W'($urandom_range(254, 2)));
    run_random(150);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.report($sformatf("%0d result words never arrived", sb.pending_results.size()));
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: sim.f
hdl/ctq_pkg.sv
hdl/ctq_ctrl.sv
hdl/ctq_dpath.sv
hdl/chunked_ticket_queue_top.sv
tb/tb_chunked_ticket_queue_top.sv
